>>> src/rtd_pkg.sv
`default_nettype none

package rtd_pkg;

    // Coordinate format: signed Q(32-F).F
    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_W = 32;

    // 1/Phi^2 in Q0.32, rounded to Q0.F
    localparam longint unsigned PHI2_Q32 = 64'd1640531527;
    localparam logic [COORD_FRAC_BITS-1:0] PHI2_K =
        COORD_FRAC_BITS'((PHI2_Q32 + (64'd1 << (31 - COORD_FRAC_BITS)))
                         >> (32 - COORD_FRAC_BITS));

    // difference is 33 bits signed, constant is F+1 bits signed (positive)
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + COORD_FRAC_BITS + 1;
    localparam logic [PROD_W-1:0] ROUND_HALF =
        PROD_W'(64'd1 << (COORD_FRAC_BITS - 1));

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    // Triangle kinds
    localparam logic KIND_ACUTE = 1'b0;
    localparam logic KIND_OBTUSE = 1'b1;

    // Child sequence within one parent
    localparam int CHILD_W = 2;
    localparam logic [CHILD_W-1:0] CHILD_0 = 2'd0;
    localparam logic [CHILD_W-1:0] CHILD_1 = 2'd1;
    localparam logic [CHILD_W-1:0] CHILD_2 = 2'd2;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] p1_x;
        logic signed [31:0] p1_y;
        logic signed [31:0] p2_x;
        logic signed [31:0] p2_y;
        logic signed [31:0] p3_x;
        logic signed [31:0] p3_y;
    } tri_in_t;

    typedef struct packed {
        logic               out_kind;
        logic signed [31:0] q1_x;
        logic signed [31:0] q1_y;
        logic signed [31:0] q2_x;
        logic signed [31:0] q2_y;
        logic signed [31:0] q3_x;
        logic signed [31:0] q3_y;
        logic               last_child;
    } tri_out_t;

    // One parent with its new points; for an acute parent b is point C
    typedef struct packed {
        tri_in_t            parent;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
    } qent_t;

    // (tip - base) * K, exact
    function automatic logic signed [PROD_W-1:0] scaled_diff(
        input logic signed [COORD_W-1:0] base,
        input logic signed [COORD_W-1:0] tip
    );
        logic signed [DIFF_W-1:0] d;
        logic signed [PROD_W-1:0] dw;
        logic signed [PROD_W-1:0] kw;
        d  = DIFF_W'(tip) - DIFF_W'(base);
        dw = PROD_W'(d);
        kw = $signed(PROD_W'(PHI2_K));
        return dw * kw;
    endfunction

    // base + round_half_up(prod / 2^F)
    function automatic logic signed [COORD_W-1:0] round_add(
        input logic signed [COORD_W-1:0] base,
        input logic signed [PROD_W-1:0]  prod
    );
        logic signed [PROD_W-1:0] biased;
        logic signed [PROD_W-1:0] step;
        biased = prod + $signed(ROUND_HALF);
        step   = biased >>> COORD_FRAC_BITS;
        return base + step[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> src/rtd_front.sv
`default_nettype none

module rtd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire rtd_pkg::tri_in_t item,
    input  wire logic            pop,
    output logic                 busy,
    output logic                 push,
    output rtd_pkg::qent_t       entry
);

    logic                          s0_valid_reg;
    rtd_pkg::tri_in_t              s0_item_reg;
    logic                          s1_valid_reg;
    rtd_pkg::tri_in_t              s1_item_reg;
    logic signed [rtd_pkg::PROD_W-1:0] s1_prod_reg [4];
    logic signed [rtd_pkg::PROD_W-1:0] s1_prod_next [4];
    logic [rtd_pkg::CNT_W-1:0]     count_reg;
    logic [rtd_pkg::CNT_W-1:0]     count_next;
    logic                          accept;

    // credit count: items accepted and not yet popped from the queue
    always_comb
    begin
        accept = start && !busy;
        count_next = count_reg;
        case ({accept, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    assign busy = (count_reg == rtd_pkg::CNT_W'(rtd_pkg::QDEPTH));

    always_comb
    begin
        s1_prod_next[0] = rtd_pkg::scaled_diff(s0_item_reg.p3_x, s0_item_reg.p1_x);
        s1_prod_next[1] = rtd_pkg::scaled_diff(s0_item_reg.p3_y, s0_item_reg.p1_y);
        s1_prod_next[2] = rtd_pkg::scaled_diff(s0_item_reg.p2_x, s0_item_reg.p1_x);
        s1_prod_next[3] = rtd_pkg::scaled_diff(s0_item_reg.p2_y, s0_item_reg.p1_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_item_reg <= item;
        end
        if (s0_valid_reg)
        begin
            s1_item_reg <= s0_item_reg;
            for (int i = 0; i < 4; i++)
            begin
                s1_prod_reg[i] <= s1_prod_next[i];
            end
        end
    end

    always_comb
    begin
        push         = s1_valid_reg;
        entry.parent = s1_item_reg;
        entry.a_x    = rtd_pkg::round_add(s1_item_reg.p3_x, s1_prod_reg[0]);
        entry.a_y    = rtd_pkg::round_add(s1_item_reg.p3_y, s1_prod_reg[1]);
        entry.b_x    = rtd_pkg::round_add(s1_item_reg.p2_x, s1_prod_reg[2]);
        entry.b_y    = rtd_pkg::round_add(s1_item_reg.p2_y, s1_prod_reg[3]);
    end

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rtd_pkg::CNT_W'(rtd_pkg::QDEPTH))
        else $error("credit count above queue depth");

endmodule

`default_nettype wire

>>> src/rtd_queue.sv
`default_nettype none

module rtd_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire rtd_pkg::qent_t entry,
    input  wire logic           pop,
    output logic                not_empty,
    output rtd_pkg::qent_t      head
);

    rtd_pkg::qent_t            mem_reg [rtd_pkg::QDEPTH];
    logic [rtd_pkg::QAW-1:0]   wr_ptr_reg;
    logic [rtd_pkg::QAW-1:0]   rd_ptr_reg;
    logic [rtd_pkg::CNT_W-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != rtd_pkg::CNT_W'(rtd_pkg::QDEPTH)) || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

endmodule

`default_nettype wire

>>> src/rtd_back.sv
`default_nettype none

module rtd_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           not_empty,
    input  wire rtd_pkg::qent_t head,
    output logic                pop,
    output logic                strobe,
    output rtd_pkg::tri_out_t   result
);

    logic [rtd_pkg::CHILD_W-1:0] idx_reg;
    logic [rtd_pkg::CHILD_W-1:0] idx_next;
    logic                        strobe_reg;
    rtd_pkg::tri_out_t           result_reg;
    rtd_pkg::tri_out_t           child;
    logic                        last;

    always_comb
    begin
        last = (head.parent.kind == rtd_pkg::KIND_OBTUSE) ? (idx_reg == rtd_pkg::CHILD_2)
                                                          : (idx_reg == rtd_pkg::CHILD_1);

        // obtuse parent, first child: (P3, A, P2)
        child.out_kind   = rtd_pkg::KIND_OBTUSE;
        child.q1_x       = head.parent.p3_x;
        child.q1_y       = head.parent.p3_y;
        child.q2_x       = head.a_x;
        child.q2_y       = head.a_y;
        child.q3_x       = head.parent.p2_x;
        child.q3_y       = head.parent.p2_y;
        child.last_child = last;

        case ({head.parent.kind, idx_reg})
            {rtd_pkg::KIND_OBTUSE, rtd_pkg::CHILD_1}:
            begin
                child.q1_x = head.a_x;
                child.q1_y = head.a_y;
                child.q2_x = head.b_x;
                child.q2_y = head.b_y;
                child.q3_x = head.parent.p1_x;
                child.q3_y = head.parent.p1_y;
            end
            {rtd_pkg::KIND_OBTUSE, rtd_pkg::CHILD_2}:
            begin
                child.out_kind = rtd_pkg::KIND_ACUTE;
                child.q1_x     = head.a_x;
                child.q1_y     = head.a_y;
                child.q2_x     = head.b_x;
                child.q2_y     = head.b_y;
            end
            {rtd_pkg::KIND_ACUTE, rtd_pkg::CHILD_0}:
            begin
                child.q2_x = head.b_x;
                child.q2_y = head.b_y;
                child.q3_x = head.parent.p1_x;
                child.q3_y = head.parent.p1_y;
            end
            {rtd_pkg::KIND_ACUTE, rtd_pkg::CHILD_1}:
            begin
                child.out_kind = rtd_pkg::KIND_ACUTE;
                child.q2_x     = head.b_x;
                child.q2_y     = head.b_y;
            end
            default:
            begin
                child.out_kind = rtd_pkg::KIND_OBTUSE;
            end
        endcase

        pop = not_empty && last;
        if (!not_empty)
        begin
            idx_next = idx_reg;
        end
        else if (last)
        begin
            idx_next = rtd_pkg::CHILD_0;
        end
        else
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= rtd_pkg::CHILD_0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            strobe_reg <= not_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (not_empty)
        begin
            result_reg <= child;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && result_reg.last_child) |-> (idx_reg == rtd_pkg::CHILD_0))
        else $error("child index not rewound after last child");

    a_acute_two: assert property (@(posedge clk) disable iff (!rst_n)
        (not_empty && head.parent.kind == rtd_pkg::KIND_ACUTE)
            |-> (idx_reg != rtd_pkg::CHILD_2))
        else $error("acute parent reached third child");

endmodule

`default_nettype wire

>>> src/robinson_triangle_deflation_core.sv
// A triangle taken on start passes the input register, product register and queue before
// its first child is registered out with strobe. Throughput: one child per cycle while the queue
// holds a parent; an obtuse parent has three children, an acute one two; the back end's child sequencer sets the rate.
// Up to 4 parents may be in flight (2 front stages plus queue); busy rises when all are used.
// Results cannot be held off: each child is shown for exactly one cycle with strobe.
// Reset (rst_n low, asynchronous) empties the pipeline and queue and drops busy.
`default_nettype none

module robinson_triangle_deflation_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire rtd_pkg::tri_in_t item,
    output logic                  busy,
    output logic                  strobe,
    output rtd_pkg::tri_out_t     result
);

    // front to queue: one transaction per parent, new points already computed
    logic           push;
    rtd_pkg::qent_t entry;

    // queue to back
    logic           not_empty;
    logic           pop;
    rtd_pkg::qent_t head;

    // Front end: register the parent, multiply the four differences by 1/Phi^2,
    // then round and add the base to form points A and B (B doubles as C).
    rtd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .pop   (pop),
        .busy  (busy),
        .push  (push),
        .entry (entry)
    );

    // Hold computed parents until the back end has emitted all their children.
    rtd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry     (entry),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    // Back end: step through the children of the head parent, one per cycle,
    // and drop the parent on its last child.
    rtd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .head      (head),
        .pop       (pop),
        .strobe    (strobe),
        .result    (result)
    );

endmodule

`default_nettype wire

>>> dv/deflation_check_pkg.sv
`default_nettype none

package deflation_check_pkg;

    import rtd_pkg::*;

    localparam int FRAC = COORD_FRAC_BITS;

    // Inverse golden-ratio square in Q0.32, rounded once to the coordinate fraction width
    localparam longint unsigned GOLDEN_SQ_Q32 = 64'd1640531527;
    localparam longint SHRINK_K =
        longint'((GOLDEN_SQ_Q32 + (64'd1 << (31 - FRAC))) >> (32 - FRAC));
    localparam longint HALF_ULP = longint'(1) << (FRAC - 1);

    localparam int REPORT_LIMIT = 10;

    class deflation_scoreboard;

        tri_out_t    expected_children[$];
        int unsigned failures;

        function new();
            failures = 0;
        endfunction

        // base + K*(tip - base), rounded half up at the fraction boundary
        function logic signed [31:0] point_toward(logic signed [31:0] base,
                                                  logic signed [31:0] tip);
            longint span;
            longint scaled;
            longint step;
            span   = longint'(tip) - longint'(base);
            scaled = span * SHRINK_K;
            step   = (scaled + HALF_ULP) >>> FRAC;
            return 32'(longint'(base) + step);
        endfunction

        // Append one expected child at the tail
        function void enqueue_child(tri_out_t c);
            expected_children.insert(expected_children.size(), c);
        endfunction

        function void note_parent(tri_in_t p);
            logic signed [31:0] ax;
            logic signed [31:0] ay;
            logic signed [31:0] bx;
            logic signed [31:0] by;
            tri_out_t           c;
            bx = point_toward(p.p2_x, p.p1_x);
            by = point_toward(p.p2_y, p.p1_y);
            if (p.kind == KIND_OBTUSE)
            begin
                ax = point_toward(p.p3_x, p.p1_x);
                ay = point_toward(p.p3_y, p.p1_y);
                c = '{KIND_OBTUSE, p.p3_x, p.p3_y, ax, ay, p.p2_x, p.p2_y, 1'b0};
                enqueue_child(c);
                c = '{KIND_OBTUSE, ax, ay, bx, by, p.p1_x, p.p1_y, 1'b0};
                enqueue_child(c);
                c = '{KIND_ACUTE, ax, ay, bx, by, p.p2_x, p.p2_y, 1'b1};
                enqueue_child(c);
            end
            else
            begin
                // acute parent: the single new point sits on the P2-P1 edge
                c = '{KIND_OBTUSE, p.p3_x, p.p3_y, bx, by, p.p1_x, p.p1_y, 1'b0};
                enqueue_child(c);
                c = '{KIND_ACUTE, p.p3_x, p.p3_y, bx, by, p.p2_x, p.p2_y, 1'b1};
                enqueue_child(c);
            end
        endfunction

        function bit differs(string field, logic [31:0] want, logic [31:0] got, bit show);
            if (want !== got)
            begin
                if (show)
                    $display("child mismatch #%0d: %s expected %h, got %h",
                             failures + 1, field, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_child(tri_out_t got);
            tri_out_t want;
            bit       bad;
            bit       show;
            show = (failures < REPORT_LIMIT);
            if (expected_children.size() == 0)
            begin
                if (show)
                    $display("unexpected child: %h", got);
                failures++;
                return;
            end
            want = expected_children.pop_front();
            bad  = 1'b0;
            bad |= differs("out_kind", 32'(want.out_kind), 32'(got.out_kind), show);
            bad |= differs("q1_x", want.q1_x, got.q1_x, show);
            bad |= differs("q1_y", want.q1_y, got.q1_y, show);
            bad |= differs("q2_x", want.q2_x, got.q2_x, show);
            bad |= differs("q2_y", want.q2_y, got.q2_y, show);
            bad |= differs("q3_x", want.q3_x, got.q3_x, show);
            bad |= differs("q3_y", want.q3_y, got.q3_y, show);
            bad |= differs("last_child", 32'(want.last_child), 32'(got.last_child), show);
            if (bad)
                failures++;
        endfunction

        function int pending();
            return expected_children.size();
        endfunction

    endclass

endpackage

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rtd_pkg::*;
    import deflation_check_pkg::*;

    // 430 parent triangles in total, directed ones included
    localparam int PARENT_COUNT = 430;
    // Run budget in cycles, with ample headroom over the slowest correct run
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles spent watching for stray children once every expected one has arrived
    localparam int DRAIN_CYCLES = 12;

    localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] UNIT     = 32'sh0001_0000;
    // a span of half a unit scales to whole LSBs plus exactly half an LSB: the rounding tie
    localparam logic signed [31:0] TIE_SPAN = 32'sh0000_8000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     strobe;
    tri_in_t  item;
    tri_out_t result;

    deflation_scoreboard sb;
    int unsigned         parents_sent;
    int unsigned         cycle_count = 0;

    robinson_triangle_deflation_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .strobe (strobe),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Guard against a hung pipeline: end the run outright once the budget is spent
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Children cannot be held off, so take every strobed transaction as it passes.
    // Sampling at the edge reads the values from the cycle that edge closes.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_child(result);
    end

    function automatic tri_in_t make_parent(logic k,
                                            logic signed [31:0] x1, logic signed [31:0] y1,
                                            logic signed [31:0] x2, logic signed [31:0] y2,
                                            logic signed [31:0] x3, logic signed [31:0] y3);
        tri_in_t p;
        p = '{k, x1, y1, x2, y2, x3, y3};
        return p;
    endfunction

    // Corner values: the range limits, zero, one LSB either way and the rounding tie
    function automatic logic signed [31:0] corner_coord();
        case ($urandom_range(0, 6))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return 32'sd0;
            3: return -32'sd1;
            4: return 32'sd1;
            5: return TIE_SPAN;
            default: return -TIE_SPAN;
        endcase
    endfunction

    // Tile-sized coordinate within +/-64.0, where real tilings live
    function automatic logic signed [31:0] tile_coord();
        return $signed($urandom_range(0, 128 * 65536)) - 32'sd4194304;
    endfunction

    function automatic tri_in_t random_parent();
        tri_in_t p;
        int      style;
        style  = $urandom_range(0, 9);
        p.kind = 1'($urandom_range(0, 1));
        if (style <= 3)
        begin
            // full-range words: every bit of every coordinate toggles
            p.p1_x = $urandom; p.p1_y = $urandom;
            p.p2_x = $urandom; p.p2_y = $urandom;
            p.p3_x = $urandom; p.p3_y = $urandom;
        end
        else if (style <= 6)
        begin
            p.p1_x = tile_coord(); p.p1_y = tile_coord();
            p.p2_x = tile_coord(); p.p2_y = tile_coord();
            p.p3_x = tile_coord(); p.p3_y = tile_coord();
        end
        else if (style <= 8)
        begin
            p.p1_x = corner_coord(); p.p1_y = corner_coord();
            p.p2_x = corner_coord(); p.p2_y = corner_coord();
            p.p3_x = corner_coord(); p.p3_y = corner_coord();
        end
        else
        begin
            // degenerate: collapse vertices onto each other, or offset by a tie span
            p.p1_x = $urandom; p.p1_y = $urandom;
            p.p2_x = ($urandom_range(0, 1) != 0) ? p.p1_x : p.p1_x - TIE_SPAN;
            p.p2_y = ($urandom_range(0, 1) != 0) ? p.p1_y : p.p1_y + TIE_SPAN;
            p.p3_x = ($urandom_range(0, 1) != 0) ? p.p2_x : p.p1_x;
            p.p3_y = ($urandom_range(0, 1) != 0) ? p.p2_y : p.p1_y;
        end
        return p;
    endfunction

    // Present a parent and hold it until a transaction completes (start high, busy low).
    // Start is left high so that a following call streams back to back.
    task automatic send_parent(tri_in_t p);
        item  <= p;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        sb.note_parent(p);
        parents_sent++;
    endtask

    // Drop start for the given number of cycles between bursts; zero leaves start high
    task automatic pause_sender(int unsigned cycles);
        if (cycles != 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic send_directed(logic k);
        // all vertices at the origin
        send_parent(make_parent(k, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
        // widest possible spans, both directions
        send_parent(make_parent(k, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                                COORD_MIN, COORD_MIN));
        send_parent(make_parent(k, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                                COORD_MAX, COORD_MAX));
        send_parent(make_parent(k, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
                                -32'sd1, 32'sd1));
        // rounding ties on a positive and a negative span
        send_parent(make_parent(k, TIE_SPAN, TIE_SPAN, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
        send_parent(make_parent(k, 32'sd0, 32'sd0, TIE_SPAN, TIE_SPAN, TIE_SPAN, TIE_SPAN));
        // a plausible tile
        send_parent(make_parent(k, UNIT, 32'sd0, 32'sd0, UNIT >>> 1, -UNIT, 32'sd0));
        // collinear and coincident vertices
        send_parent(make_parent(k, 3 * UNIT, 3 * UNIT, UNIT, UNIT, 2 * UNIT, 2 * UNIT));
        send_parent(make_parent(k, -32'sd360448, 32'sd475136, -32'sd360448, 32'sd475136,
                                -32'sd360448, 32'sd475136));
    endtask

    initial
    begin
        sb           = new();
        parents_sent = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        item         = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed parents, streamed back to back so the queue fills and busy rises
        send_directed(KIND_OBTUSE);
        send_directed(KIND_ACUTE);
        pause_sender(20);

        // Random parents in bursts of random length, with gaps that land on
        // every phase of the child sequencer and, now and then, a full drain
        while (parents_sent < PARENT_COUNT)
        begin
            int unsigned burst;
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                if (parents_sent < PARENT_COUNT)
                    send_parent(random_parent());
            end
            case ($urandom_range(0, 7))
                0, 1: pause_sender(0);
                7:    pause_sender($urandom_range(15, 40));
                default: pause_sender($urandom_range(1, 8));
            endcase
        end
        start <= 1'b0;

        // Hold until every expected child has arrived, then watch for strays
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
